FILE: rtl/core/owts_pkg.sv
// Package for the 1-Wire temperature sensor slave model.
// Holds the bus event codes, the job descriptor passed from front to back,
// and the CRC-8 helpers. Used by every module of the block.
package owts_pkg;

  // Bus event codes carried in the kind field.
  typedef enum logic [2:0] {
    KIND_BUS_RESET    = 3'd0,
    KIND_WRITE        = 3'd1,
    KIND_READ         = 3'd2,
    KIND_SEARCH_RESET = 3'd3,
    KIND_SEARCH       = 3'd4
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_TEMPERATURE = 1'b0,
    CFG_ROM_SERIAL  = 1'b1
  } cfg_index_e;

  // Work handed from the front part to the back part.
  typedef enum logic [1:0] {
    JOB_PRESENT = 2'd0,
    JOB_SP_BYTE = 2'd1,
    JOB_EMPTY   = 2'd2,
    JOB_ROM     = 2'd3
  } job_op_e;

  localparam int unsigned SP_BYTES  = 9;
  localparam int unsigned SP_POS_W  = 4;
  localparam int unsigned ROM_BYTES = 8;
  localparam int unsigned ROM_IDX_W = $clog2(ROM_BYTES);

  typedef struct packed {
    job_op_e              op;
    logic [SP_POS_W-1:0]  pos;
  } job_t;

  // Job queue sizing.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register widths and reset values.
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned SERIAL_W = 48;
  localparam int unsigned CFG_W    = SERIAL_W;
  localparam logic [TEMP_W-1:0]   TEMP_RESET   = 12'd720;
  localparam logic [SERIAL_W-1:0] SERIAL_RESET = 48'h0100_0000_0000;

  // Protocol constants.
  localparam logic [7:0] CMD_READ_SP = 8'hBE;
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] ROM_FAMILY  = 8'h28;
  localparam logic [7:0] BYTE_EMPTY  = 8'hFF;

  // Fixed scratchpad bytes 2 to 7.
  localparam logic [7:0] SP_FIXED [6] = '{8'h4B, 8'h46, 8'h7F, 8'hFF, 8'h0C, 8'h10};

  // One byte of the reflected CRC-8, LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] v;
    logic       mix;
    c = crc_in;
    v = data;
    for (int b = 0; b < 8; b++) begin
      mix = c[0] ^ v[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      v = v >> 1;
    end
    return c;
  endfunction

  // CRC over the six fixed scratchpad bytes, starting from a given value.
  // Only evaluated on constants to build the mixing table below.
  function automatic logic [7:0] crc_tail(input logic [7:0] crc_in);
    logic [7:0] c;
    c = crc_in;
    for (int i = 0; i < 6; i++) begin
      c = crc8_byte(c, SP_FIXED[i]);
    end
    return c;
  endfunction

  // The tail is affine in its start value: a constant plus one column per bit.
  localparam logic [7:0] TAIL_K = crc_tail(8'h00);
  localparam logic [7:0] TAIL_COL [8] = '{
    crc_tail(8'h01) ^ TAIL_K, crc_tail(8'h02) ^ TAIL_K,
    crc_tail(8'h04) ^ TAIL_K, crc_tail(8'h08) ^ TAIL_K,
    crc_tail(8'h10) ^ TAIL_K, crc_tail(8'h20) ^ TAIL_K,
    crc_tail(8'h40) ^ TAIL_K, crc_tail(8'h80) ^ TAIL_K
  };

  // Final scratchpad CRC from the CRC after the two temperature bytes.
  function automatic logic [7:0] sp_crc_mix(input logic [7:0] crc_mid);
    logic [7:0] r;
    r = TAIL_K;
    for (int i = 0; i < 8; i++) begin
      if (crc_mid[i]) begin
        r = r ^ TAIL_COL[i];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/owts_front.sv
// Front part: accepts bus events, keeps the command and position state,
// and queues one job per event that produces results. Uses owts_pkg.
module owts_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           kind_i,
  input  logic [7:0]           data_in_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output owts_pkg::job_t       job_o
);
  import owts_pkg::*;

  logic [7:0]          cmd_q, cmd_d;
  logic [SP_POS_W-1:0] pos_q, pos_d;
  logic                srch_done_q, srch_done_d;
  logic                accept;

  // Stall only when there is no room for a job.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the event and update the state.
  always_comb begin
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    srch_done_d = srch_done_q;
    push_o      = 1'b0;
    job_o.op    = JOB_EMPTY;
    job_o.pos   = pos_q;
    if (accept) begin
      case (kind_e'(kind_i))
        KIND_BUS_RESET: begin
          pos_d    = '0;
          push_o   = 1'b1;
          job_o.op = JOB_PRESENT;
        end
        KIND_WRITE: begin
          cmd_d = data_in_i;
          pos_d = '0;
        end
        KIND_READ: begin
          push_o = 1'b1;
          if (cmd_q == CMD_READ_SP && pos_q < SP_POS_W'(SP_BYTES)) begin
            job_o.op = JOB_SP_BYTE;
            pos_d    = pos_q + SP_POS_W'(1);
          end else begin
            job_o.op = JOB_EMPTY;
          end
        end
        KIND_SEARCH_RESET: begin
          srch_done_d = 1'b0;
        end
        KIND_SEARCH: begin
          push_o = 1'b1;
          if (srch_done_q) begin
            job_o.op = JOB_EMPTY;
          end else begin
            job_o.op    = JOB_ROM;
            srch_done_d = 1'b1;
          end
        end
        default: begin
          // Unused codes are dropped.
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= '0;
      pos_q       <= '0;
      srch_done_q <= 1'b0;
    end else begin
      cmd_q       <= cmd_d;
      pos_q       <= pos_d;
      srch_done_q <= srch_done_d;
    end
  end

endmodule

FILE: rtl/core/owts_queue.sv
// Short job queue between the front and back parts.
// Register-based FIFO of owts_pkg::job_t entries.
module owts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  owts_pkg::job_t job_i,
  input  logic           pop_i,
  output owts_pkg::job_t job_o,
  output logic           valid_o,
  output logic           full_o
);
  import owts_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign job_o   = mem_q[rd_ptr_q];

  // Occupancy follows push and pop together.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  // Pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job popped from an empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

FILE: rtl/core/owts_back.sv
// Back part: holds the configuration registers, turns jobs into result
// beats and streams ROM bytes with a running CRC. Uses owts_pkg.
module owts_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [owts_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          q_valid_i,
  input  owts_pkg::job_t                q_job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    read_data_o,
  output logic                          present_o,
  output logic                          found_o,
  output logic                          last_o
);
  import owts_pkg::*;

  logic [TEMP_W-1:0]    temp_q;
  logic [SERIAL_W-1:0]  serial_q;
  logic [7:0]           crc0_q;
  logic [7:0]           temp_lo, temp_hi, sp_crc;

  logic                 busy_q, busy_d;
  logic [ROM_IDX_W-1:0] idx_q, idx_d;
  logic [7:0]           crc_q, crc_d;
  logic [7:0]           rom_byte;
  logic                 slot_free;

  logic                 out_valid_q, out_valid_d;
  logic [7:0]           data_q, data_d;
  logic                 present_q, present_d;
  logic                 found_q, found_d;
  logic                 last_q, last_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q   <= TEMP_RESET;
      serial_q <= SERIAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_TEMPERATURE: temp_q   <= cfg_wdata_i[TEMP_W-1:0];
        CFG_ROM_SERIAL:  serial_q <= cfg_wdata_i[SERIAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Scratchpad temperature bytes, sign-extended to 16 bits.
  assign temp_lo = temp_q[7:0];
  assign temp_hi = {{4{temp_q[TEMP_W-1]}}, temp_q[TEMP_W-1:8]};

  // Scratchpad CRC: first byte is registered, the rest follows in one step.
  always_ff @(posedge clk_i) begin
    crc0_q <= crc8_byte(8'h00, temp_lo);
  end
  assign sp_crc = sp_crc_mix(crc8_byte(crc0_q, temp_hi));

  // ROM byte at the current burst index.
  always_comb begin
    case (idx_q)
      3'd1:    rom_byte = serial_q[7:0];
      3'd2:    rom_byte = serial_q[15:8];
      3'd3:    rom_byte = serial_q[23:16];
      3'd4:    rom_byte = serial_q[31:24];
      3'd5:    rom_byte = serial_q[39:32];
      3'd6:    rom_byte = serial_q[47:40];
      3'd7:    rom_byte = crc_q;
      default: rom_byte = ROM_FAMILY;
    endcase
  end

  // The output register can take a beat when empty or being drained.
  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = slot_free && !busy_q && q_valid_i;

  // Result selection.
  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    data_d      = data_q;
    present_d   = present_q;
    found_d     = found_q;
    last_d      = last_q;
    if (slot_free) begin
      out_valid_d = 1'b0;
      if (busy_q) begin
        // Continue a ROM burst.
        out_valid_d = 1'b1;
        data_d      = rom_byte;
        present_d   = 1'b0;
        found_d     = 1'b1;
        last_d      = (idx_q == ROM_IDX_W'(ROM_BYTES - 1));
        crc_d       = crc8_byte(crc_q, rom_byte);
        idx_d       = idx_q + ROM_IDX_W'(1);
        if (idx_q == ROM_IDX_W'(ROM_BYTES - 1)) begin
          busy_d = 1'b0;
        end
      end else if (q_valid_i) begin
        out_valid_d = 1'b1;
        present_d   = 1'b0;
        found_d     = 1'b0;
        last_d      = 1'b1;
        case (q_job_i.op)
          JOB_PRESENT: begin
            data_d    = 8'h00;
            present_d = 1'b1;
          end
          JOB_SP_BYTE: begin
            case (q_job_i.pos)
              4'd0:    data_d = temp_lo;
              4'd1:    data_d = temp_hi;
              4'd2:    data_d = SP_FIXED[0];
              4'd3:    data_d = SP_FIXED[1];
              4'd4:    data_d = SP_FIXED[2];
              4'd5:    data_d = SP_FIXED[3];
              4'd6:    data_d = SP_FIXED[4];
              4'd7:    data_d = SP_FIXED[5];
              default: data_d = sp_crc;
            endcase
          end
          JOB_ROM: begin
            // First ROM byte goes out now, the other seven follow.
            data_d  = ROM_FAMILY;
            found_d = 1'b1;
            last_d  = 1'b0;
            crc_d   = crc8_byte(8'h00, ROM_FAMILY);
            idx_d   = ROM_IDX_W'(1);
            busy_d  = 1'b1;
          end
          default: begin
            data_d = BYTE_EMPTY;
          end
        endcase
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    crc_q     <= crc_d;
    data_q    <= data_d;
    present_q <= present_d;
    found_q   <= found_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = data_q;
  assign present_o   = present_q;
  assign found_o     = found_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_mid_burst_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> found_o)
    else $error("non-final beat outside a ROM burst");
  a_burst_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pop_o)
    else $error("job popped during a ROM burst");
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && slot_free && idx_q != ROM_IDX_W'(ROM_BYTES - 1)) |=> busy_q)
    else $error("ROM burst ended early");
`endif

endmodule

FILE: rtl/core/one_wire_thermometer_slave_model_top.sv
// Top level of the 1-Wire temperature sensor slave model.
// Connects owts_front, owts_queue and owts_back; uses owts_pkg.
//
// Usage:
//   Input channel: one bus event per beat (kind_i, data_in_i) under
//   in_valid_i / in_stall_o. Write and search-reset events make no result;
//   bus reset, read and search events make result beats on the output
//   channel (read_data_o, present_o, found_o, last_o) under out_valid_o /
//   out_stall_i. last_o marks the final beat of one event.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (0 temperature, 1 ROM serial) on the clock edge; the user must write
//   them only while the block is idle, which the block does not enforce.
//   Timing: an accepted event goes into the job queue and its result beats
//   leave from the output register. Throughput: one event per cycle while
//   in_stall_o is low; a search that emits the ROM sends eight ROM bytes,
//   one per cycle while out_stall_i is low, the ROM CRC built as they go out.
//   A four-entry job queue sits between the event decoder and the result
//   stage; when the receiver stalls, the queue fills and in_stall_o rises
//   only once it is full. Results are never dropped or repeated.
//   Reset (rst_ni low) clears the command, read position, search flag,
//   queue and output valid, and loads the register reset values.
module one_wire_thermometer_slave_model_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 kind_i,
  input  logic [7:0]                 data_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 read_data_o,
  output logic                       present_o,
  output logic                       found_o,
  output logic                       last_o,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [owts_pkg::CFG_W-1:0] cfg_wdata_i
);
  import owts_pkg::*;

  logic q_full, q_valid, push, pop;
  job_t push_job, head_job;

  // Event decoder and state.
  owts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .data_in_i  (data_in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Job queue.
  owts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  // Result stage.
  owts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_job_i     (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .present_o   (present_o),
    .found_o     (found_o),
    .last_o      (last_o)
  );

endmodule
